FILE: design/cmpp_pkg.sv
package cmpp_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  field_tag;
        logic [63:0] field_value;
        logic        field_last;
        logic [7:0]  mention_number;
        logic        payload_done;
        logic [2:0]  parse_status;
    } out_item_t;

    // parse phases
    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_FLAGS  = 5'd1;
    localparam logic [4:0] PH_STAMP  = 5'd2;
    localparam logic [4:0] PH_ILEN   = 5'd3;
    localparam logic [4:0] PH_IDATA  = 5'd4;
    localparam logic [4:0] PH_SLEN   = 5'd5;
    localparam logic [4:0] PH_SDATA  = 5'd6;
    localparam logic [4:0] PH_CLENH  = 5'd7;
    localparam logic [4:0] PH_CLENL  = 5'd8;
    localparam logic [4:0] PH_CDATA  = 5'd9;
    localparam logic [4:0] PH_OLEN   = 5'd10;
    localparam logic [4:0] PH_ODATA  = 5'd11;
    localparam logic [4:0] PH_RLEN   = 5'd12;
    localparam logic [4:0] PH_RDATA  = 5'd13;
    localparam logic [4:0] PH_PLEN   = 5'd14;
    localparam logic [4:0] PH_PHI    = 5'd15;
    localparam logic [4:0] PH_PLO    = 5'd16;
    localparam logic [4:0] PH_MCOUNT = 5'd17;
    localparam logic [4:0] PH_MLEN   = 5'd18;
    localparam logic [4:0] PH_MDATA  = 5'd19;
    localparam logic [4:0] PH_HLEN   = 5'd20;
    localparam logic [4:0] PH_HDATA  = 5'd21;
    localparam logic [4:0] PH_FINISH = 5'd22;

    // field tags
    localparam logic [3:0] TAG_FLAGS     = 4'd0;
    localparam logic [3:0] TAG_STAMP     = 4'd1;
    localparam logic [3:0] TAG_ID        = 4'd2;
    localparam logic [3:0] TAG_SENDER    = 4'd3;
    localparam logic [3:0] TAG_CONTENT   = 4'd4;
    localparam logic [3:0] TAG_ENC       = 4'd5;
    localparam logic [3:0] TAG_ORIG      = 4'd6;
    localparam logic [3:0] TAG_RECIP     = 4'd7;
    localparam logic [3:0] TAG_PEER      = 4'd8;
    localparam logic [3:0] TAG_MENTION   = 4'd9;
    localparam logic [3:0] TAG_CHANNEL   = 4'd10;
    localparam logic [3:0] TAG_STATUS    = 4'd11;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_ID_OVF    = 3'd2;
    localparam logic [2:0] ST_SNDR_OVF  = 3'd3;
    localparam logic [2:0] ST_CONT_OVF  = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    localparam logic [15:0] MIN_PAYLOAD = 16'd13;
    localparam logic [7:0]  FLAG_ENC    = 8'h80;

    localparam int unsigned NUM_OPT = 5;
    localparam logic [7:0] OPT_MASK [NUM_OPT] = '{8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
    localparam logic [4:0] OPT_PHASE [NUM_OPT] =
        '{PH_OLEN, PH_RLEN, PH_PLEN, PH_MCOUNT, PH_HLEN};

    // first optional field at or after slot k whose flag is set
    function automatic logic [4:0] next_opt(input logic [7:0] flags, input logic [2:0] k);
        logic [4:0] r;
        r = PH_FINISH;
        for (int i = NUM_OPT - 1; i >= 0; i--) begin
            if ((3'(i) >= k) && ((flags & OPT_MASK[i]) != 8'h00)) begin
                r = OPT_PHASE[i];
            end
        end
        return r;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: design/cmpp_core.sv
module cmpp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  cmpp_pkg::in_item_t item,
    output logic              res_valid,
    output cmpp_pkg::out_item_t res
);
    import cmpp_pkg::*;

    logic [4:0]  phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  flags_reg, flags_next;
    logic [63:0] stamp_reg, stamp_next;
    logic [7:0]  mleft_reg, mleft_next;
    logic [7:0]  mcount_reg, mcount_next;
    logic [4:0]  nibble_reg, nibble_next;
    logic        stopped_reg, stopped_next;

    // effective state after a possible restart
    logic [4:0]  ph_e;
    logic [15:0] pos_e, tot_e, rem_e;
    logic [7:0]  flg_e, ml_e, mc_e;
    logic [63:0] stp_e;
    logic [4:0]  nib_e;
    logic        stop_e;

    logic [7:0]  b;
    logic [15:0] pos1, room, len16, rem_dec;
    logic [4:0]  nxt, hx;
    logic [7:0]  ml_dec;
    logic        have, ended, last;
    logic [3:0]  tag;
    logic [2:0]  status;
    logic [7:0]  mnum;
    logic [63:0] val;

    always_comb begin
        b      = item.data_byte;
        ph_e   = item.first_byte ? PH_FLAGS : phase_reg;
        pos_e  = item.first_byte ? 16'd0 : pos_reg;
        tot_e  = item.first_byte ? item.payload_length : total_reg;
        rem_e  = item.first_byte ? 16'd0 : remain_reg;
        flg_e  = item.first_byte ? 8'd0 : flags_reg;
        stp_e  = item.first_byte ? 64'd0 : stamp_reg;
        ml_e   = item.first_byte ? 8'd0 : mleft_reg;
        mc_e   = item.first_byte ? 8'd0 : mcount_reg;
        nib_e  = item.first_byte ? 5'd0 : nibble_reg;
        stop_e = item.first_byte ? 1'b0 : stopped_reg;

        pos1    = pos_e + 16'd1;
        room    = tot_e - pos1;
        rem_dec = rem_e - 16'd1;
        ml_dec  = ml_e - 8'd1;
        len16   = rem_e | {8'd0, b};
        hx      = hex_val(b);

        phase_next   = ph_e;
        pos_next     = pos_e;
        total_next   = tot_e;
        remain_next  = rem_e;
        flags_next   = flg_e;
        stamp_next   = stp_e;
        mleft_next   = ml_e;
        mcount_next  = mc_e;
        nibble_next  = nib_e;
        stopped_next = stop_e;

        have   = 1'b0;
        ended  = 1'b0;
        last   = 1'b0;
        tag    = TAG_STATUS;
        status = ST_OK;
        mnum   = 8'd0;
        val    = 64'd0;
        nxt    = ph_e;

        if (item.first_byte && item.payload_length < MIN_PAYLOAD) begin
            // too short: answer on the first beat and ignore the rest
            stopped_next = 1'b1;
            phase_next   = PH_IDLE;
            res_valid    = 1'b1;
            res          = '{field_tag: TAG_STATUS, field_value: 64'd0, field_last: 1'b0,
                             mention_number: 8'd0, payload_done: 1'b1,
                             parse_status: ST_SHORT};
        end else if (stop_e || ph_e == PH_IDLE || ph_e == PH_FINISH || pos_e >= tot_e) begin
            res_valid = 1'b0;
            res       = '0;
        end else begin
            pos_next = pos1;
            case (ph_e)
                PH_FLAGS: begin
                    flags_next  = b;
                    have        = 1'b1;
                    tag         = TAG_FLAGS;
                    val         = {56'd0, b};
                    last        = 1'b1;
                    remain_next = 16'd8;
                    stamp_next  = 64'd0;
                    nxt         = PH_STAMP;
                end
                PH_STAMP: begin
                    stamp_next  = {stp_e[55:0], b};
                    remain_next = rem_dec;
                    if (rem_dec == 16'd0) begin
                        have = 1'b1;
                        tag  = TAG_STAMP;
                        val  = {stp_e[55:0], b};
                        last = 1'b1;
                        nxt  = PH_ILEN;
                    end
                end
                PH_ILEN, PH_SLEN, PH_OLEN, PH_RLEN, PH_PLEN, PH_HLEN: begin
                    if (ph_e == PH_PLEN) begin
                        nibble_next = 5'd0;
                    end
                    if ({8'd0, b} > room) begin
                        ended = 1'b1;
                        case (ph_e)
                            PH_ILEN: status = ST_ID_OVF;
                            PH_SLEN: status = ST_SNDR_OVF;
                            default: status = ST_TRUNC;
                        endcase
                    end else begin
                        remain_next = {8'd0, b};
                        if (b != 8'd0) begin
                            case (ph_e)
                                PH_ILEN: nxt = PH_IDATA;
                                PH_SLEN: nxt = PH_SDATA;
                                PH_OLEN: nxt = PH_ODATA;
                                PH_RLEN: nxt = PH_RDATA;
                                PH_PLEN: nxt = PH_PHI;
                                default: nxt = PH_HDATA;
                            endcase
                        end else begin
                            case (ph_e)
                                PH_ILEN: nxt = PH_SLEN;
                                PH_SLEN: nxt = PH_CLENH;
                                PH_OLEN: nxt = next_opt(flg_e, 3'd1);
                                PH_RLEN: nxt = next_opt(flg_e, 3'd2);
                                PH_PLEN: nxt = next_opt(flg_e, 3'd3);
                                default: nxt = PH_FINISH;
                            endcase
                        end
                    end
                end
                PH_CLENH: begin
                    remain_next = {b, 8'd0};
                    nxt         = PH_CLENL;
                end
                PH_CLENL: begin
                    if (len16 > room) begin
                        ended  = 1'b1;
                        status = ST_CONT_OVF;
                    end else begin
                        remain_next = len16;
                        nxt = (len16 != 16'd0) ? PH_CDATA : next_opt(flg_e, 3'd0);
                    end
                end
                PH_PHI: begin
                    nibble_next = hx[4] ? hx : 5'd0;
                    remain_next = rem_dec;
                    nxt = (rem_dec != 16'd0) ? PH_PLO : next_opt(flg_e, 3'd3);
                end
                PH_PLO: begin
                    remain_next = rem_dec;
                    if (hx[4] && nib_e[4]) begin
                        have = 1'b1;
                        tag  = TAG_PEER;
                        val  = {56'd0, nib_e[3:0], hx[3:0]};
                        last = rem_dec <= 16'd1;
                    end
                    nibble_next = 5'd0;
                    nxt = (rem_dec != 16'd0) ? PH_PHI : next_opt(flg_e, 3'd3);
                end
                PH_MCOUNT: begin
                    if (b == 8'd0) begin
                        nxt = next_opt(flg_e, 3'd4);
                    end else begin
                        mleft_next  = b;
                        mcount_next = 8'd0;
                        nxt         = PH_MLEN;
                    end
                end
                PH_MLEN: begin
                    if ({8'd0, b} > room) begin
                        ended  = 1'b1;
                        status = ST_TRUNC;
                    end else if (b == 8'd0) begin
                        mcount_next = mc_e + 8'd1;
                        mleft_next  = ml_dec;
                        nxt = (ml_dec != 8'd0) ? PH_MLEN : next_opt(flg_e, 3'd4);
                    end else begin
                        remain_next = {8'd0, b};
                        nxt         = PH_MDATA;
                    end
                end
                PH_MDATA: begin
                    have        = 1'b1;
                    tag         = TAG_MENTION;
                    val         = {56'd0, b};
                    mnum        = mc_e;
                    remain_next = rem_dec;
                    if (rem_dec == 16'd0) begin
                        last        = 1'b1;
                        mcount_next = mc_e + 8'd1;
                        mleft_next  = ml_dec;
                        nxt = (ml_dec != 8'd0) ? PH_MLEN : next_opt(flg_e, 3'd4);
                    end
                end
                default: begin
                    // plain data bytes of id, sender, content, orig sender, recipient, channel
                    have        = 1'b1;
                    val         = {56'd0, b};
                    remain_next = rem_dec;
                    case (ph_e)
                        PH_IDATA: tag = TAG_ID;
                        PH_SDATA: tag = TAG_SENDER;
                        PH_CDATA: tag = ((flg_e & FLAG_ENC) != 8'h00) ? TAG_ENC : TAG_CONTENT;
                        PH_ODATA: tag = TAG_ORIG;
                        PH_RDATA: tag = TAG_RECIP;
                        default:  tag = TAG_CHANNEL;
                    endcase
                    if (rem_dec == 16'd0) begin
                        last = 1'b1;
                        case (ph_e)
                            PH_IDATA: nxt = PH_SLEN;
                            PH_SDATA: nxt = PH_CLENH;
                            PH_CDATA: nxt = next_opt(flg_e, 3'd0);
                            PH_ODATA: nxt = next_opt(flg_e, 3'd1);
                            PH_RDATA: nxt = next_opt(flg_e, 3'd2);
                            default:  nxt = PH_FINISH;
                        endcase
                    end
                end
            endcase

            if (!ended) begin
                if (nxt == PH_FINISH) begin
                    ended = 1'b1;
                end else if (room == 16'd0) begin
                    // payload ran out: fine before an optional field, else truncated
                    ended  = 1'b1;
                    status = (nxt inside {PH_OLEN, PH_RLEN, PH_PLEN, PH_MCOUNT, PH_MLEN,
                                          PH_HLEN}) ? ST_OK : ST_TRUNC;
                end
            end
            if (ended) begin
                stopped_next = 1'b1;
                phase_next   = PH_FINISH;
            end else begin
                phase_next = nxt;
            end

            res_valid = have || ended;
            if (have) begin
                res = '{field_tag: tag, field_value: val, field_last: last,
                        mention_number: mnum, payload_done: ended,
                        parse_status: ended ? status : ST_OK};
            end else begin
                res = '{field_tag: TAG_STATUS, field_value: 64'd0, field_last: 1'b0,
                        mention_number: 8'd0, payload_done: ended,
                        parse_status: ended ? status : ST_OK};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= 16'd0;
            total_reg   <= 16'd0;
            remain_reg  <= 16'd0;
            flags_reg   <= 8'd0;
            stamp_reg   <= 64'd0;
            mleft_reg   <= 8'd0;
            mcount_reg  <= 8'd0;
            nibble_reg  <= 5'd0;
            stopped_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            remain_reg  <= remain_next;
            flags_reg   <= flags_next;
            stamp_reg   <= stamp_next;
            mleft_reg   <= mleft_next;
            mcount_reg  <= mcount_next;
            nibble_reg  <= nibble_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

FILE: design/chat_message_payload_parser.sv
// Channel   Direction  Payload                 Handshake
// s_        in         cmpp_pkg::in_item_t     s_valid / s_ready
// m_        out        cmpp_pkg::out_item_t    m_valid / m_ready
//
// One payload byte per cycle, sustained unless a full result register waits on m_ready.
// Each beat sits in an input register, goes through the combinational parser logic and
// its result, if any, lands in the result register, from which it shows on m_.
// aresetn (synchronous) clears the parse state and both valid flags.
// s_ready drops only while the input register holds a beat and the result
// register is full and not being taken.
module chat_message_payload_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cmpp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cmpp_pkg::out_item_t m_item
);
    import cmpp_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    logic      advance;
    logic      res_valid;
    out_item_t res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cmpp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && res_valid) begin
            out_item_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmpp_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_item;

    chat_message_payload_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // parser shadow state
    logic [4:0]  ph;
    logic [15:0] pos;
    logic [15:0] tot;
    logic [15:0] rem;
    logic [7:0]  flg;
    logic [63:0] stamp;
    logic [7:0]  ment_left;
    logic [7:0]  ment_idx;
    logic [4:0]  nib;
    logic        halted;

    out_item_t   expected_fields[$];
    logic [7:0]  msg_bytes[$];
    int unsigned src_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned field_errors;

    always #6 aclk = ~aclk;

    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic void expect_item(input out_item_t r);
        expected_fields.insert(expected_fields.size(), r);
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        msg_bytes.insert(msg_bytes.size(), v);
    endfunction

    function automatic void clear_parser();
        ph        = PH_IDLE;
        pos       = '0;
        tot       = '0;
        rem       = '0;
        flg       = '0;
        stamp     = '0;
        ment_left = '0;
        ment_idx  = '0;
        nib       = '0;
        halted    = 1'b0;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    // optional slots 0..4 map to flag bits 2..6
    function automatic logic [4:0] following_field(input int unsigned k);
        for (int unsigned i = k; i < 5; i++) begin
            if (flg[i + 2]) begin
                case (i)
                    0: return PH_OLEN;
                    1: return PH_RLEN;
                    2: return PH_PLEN;
                    3: return PH_MCOUNT;
                    default: return PH_HLEN;
                endcase
            end
        end
        return PH_FINISH;
    endfunction

    function automatic logic [4:0] close_mention();
        ment_idx  = ment_idx + 8'd1;
        ment_left = ment_left - 8'd1;
        return (ment_left != 0) ? PH_MLEN : following_field(4);
    endfunction

    function automatic logic is_opt_length(input logic [4:0] p);
        return p inside {PH_OLEN, PH_RLEN, PH_PLEN, PH_MCOUNT, PH_MLEN, PH_HLEN};
    endfunction

    function automatic void parse_byte(input in_item_t it);
        logic [7:0]  b;
        logic        have;
        logic        ended;
        logic        last;
        logic [3:0]  tag;
        logic [2:0]  st;
        logic [7:0]  mnum;
        logic [63:0] val;
        logic [15:0] room;
        logic [15:0] clen;
        logic [4:0]  nxt;
        logic [4:0]  after;
        logic [4:0]  hx;
        out_item_t   r;
        b     = it.data_byte;
        have  = 1'b0;
        ended = 1'b0;
        last  = 1'b0;
        tag   = TAG_STATUS;
        st    = ST_OK;
        mnum  = '0;
        val   = '0;
        if (it.first_byte) begin
            clear_parser();
            tot = it.payload_length;
            ph  = PH_FLAGS;
            if (tot < MIN_PAYLOAD) begin
                halted = 1'b1;
                ph     = PH_IDLE;
                r = '0;
                r.field_tag    = TAG_STATUS;
                r.payload_done = 1'b1;
                r.parse_status = ST_SHORT;
                expect_item(r);
                return;
            end
        end
        if (halted || ph == PH_IDLE || ph == PH_FINISH || pos >= tot) return;

        pos  = pos + 16'd1;
        room = tot - pos;
        nxt  = ph;
        case (ph)
            PH_FLAGS: begin
                flg   = b;
                have  = 1'b1;
                tag   = TAG_FLAGS;
                val   = {56'd0, b};
                last  = 1'b1;
                rem   = 16'd8;
                stamp = '0;
                nxt   = PH_STAMP;
            end
            PH_STAMP: begin
                stamp = {stamp[55:0], b};
                rem   = rem - 16'd1;
                if (rem == 0) begin
                    have = 1'b1;
                    tag  = TAG_STAMP;
                    val  = stamp;
                    last = 1'b1;
                    nxt  = PH_ILEN;
                end
            end
            PH_ILEN: begin
                if (b > room) begin
                    ended = 1'b1;
                    st    = ST_ID_OVF;
                end else begin
                    rem = {8'd0, b};
                    nxt = (b != 0) ? PH_IDATA : PH_SLEN;
                end
            end
            PH_SLEN: begin
                if (b > room) begin
                    ended = 1'b1;
                    st    = ST_SNDR_OVF;
                end else begin
                    rem = {8'd0, b};
                    nxt = (b != 0) ? PH_SDATA : PH_CLENH;
                end
            end
            PH_CLENH: begin
                rem = {b, 8'd0};
                nxt = PH_CLENL;
            end
            PH_CLENL: begin
                clen = rem | {8'd0, b};
                if (clen > room) begin
                    ended = 1'b1;
                    st    = ST_CONT_OVF;
                end else begin
                    rem = clen;
                    nxt = (clen != 0) ? PH_CDATA : following_field(0);
                end
            end
            PH_OLEN, PH_RLEN, PH_PLEN, PH_HLEN: begin
                if (ph == PH_PLEN) nib = '0;
                if (b > room) begin
                    ended = 1'b1;
                    st    = ST_TRUNC;
                end else begin
                    rem = {8'd0, b};
                    case (ph)
                        PH_OLEN: nxt = (b != 0) ? PH_ODATA : following_field(1);
                        PH_RLEN: nxt = (b != 0) ? PH_RDATA : following_field(2);
                        PH_PLEN: nxt = (b != 0) ? PH_PHI : following_field(3);
                        default: nxt = (b != 0) ? PH_HDATA : PH_FINISH;
                    endcase
                end
            end
            PH_PHI: begin
                hx  = hex_digit(b);
                nib = hx[4] ? hx : 5'd0;
                rem = rem - 16'd1;
                nxt = (rem != 0) ? PH_PLO : following_field(3);
            end
            PH_PLO: begin
                hx  = hex_digit(b);
                rem = rem - 16'd1;
                if (hx[4] && nib[4]) begin
                    have = 1'b1;
                    tag  = TAG_PEER;
                    val  = {56'd0, nib[3:0], hx[3:0]};
                    last = (rem <= 16'd1);
                end
                nib = '0;
                nxt = (rem != 0) ? PH_PHI : following_field(3);
            end
            PH_MCOUNT: begin
                if (b == 0) begin
                    nxt = following_field(4);
                end else begin
                    ment_left = b;
                    ment_idx  = '0;
                    nxt       = PH_MLEN;
                end
            end
            PH_MLEN: begin
                if (b > room) begin
                    ended = 1'b1;
                    st    = ST_TRUNC;
                end else if (b == 0) begin
                    nxt = close_mention();
                end else begin
                    rem = {8'd0, b};
                    nxt = PH_MDATA;
                end
            end
            PH_MDATA: begin
                have = 1'b1;
                tag  = TAG_MENTION;
                val  = {56'd0, b};
                mnum = ment_idx;
                rem  = rem - 16'd1;
                if (rem == 0) begin
                    last = 1'b1;
                    nxt  = close_mention();
                end
            end
            default: begin
                case (ph)
                    PH_IDATA: begin
                        tag   = TAG_ID;
                        after = PH_SLEN;
                    end
                    PH_SDATA: begin
                        tag   = TAG_SENDER;
                        after = PH_CLENH;
                    end
                    PH_CDATA: begin
                        tag   = ((flg & FLAG_ENC) != 0) ? TAG_ENC : TAG_CONTENT;
                        after = following_field(0);
                    end
                    PH_ODATA: begin
                        tag   = TAG_ORIG;
                        after = following_field(1);
                    end
                    PH_RDATA: begin
                        tag   = TAG_RECIP;
                        after = following_field(2);
                    end
                    default: begin
                        tag   = TAG_CHANNEL;
                        after = PH_FINISH;
                    end
                endcase
                have = 1'b1;
                val  = {56'd0, b};
                rem  = rem - 16'd1;
                if (rem == 0) begin
                    last = 1'b1;
                    nxt  = after;
                end
            end
        endcase

        if (!ended) begin
            if (nxt == PH_FINISH) begin
                ended = 1'b1;
            end else if (room == 0) begin
                ended = 1'b1;
                st    = is_opt_length(nxt) ? ST_OK : ST_TRUNC;
            end
        end
        if (ended) begin
            halted = 1'b1;
            ph     = PH_FINISH;
        end else begin
            ph = nxt;
        end

        if (!have && !ended) return;
        if (!have) begin
            tag  = TAG_STATUS;
            val  = '0;
            last = 1'b0;
            mnum = '0;
        end
        r.field_tag      = tag;
        r.field_value    = val;
        r.field_last     = last;
        r.mention_number = mnum;
        r.payload_done   = ended;
        r.parse_status   = ended ? st : ST_OK;
        expect_item(r);
    endfunction

    // result side: random backpressure, compare against oldest expectation
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_fields.size() == 0) begin
                field_errors++;
                if (field_errors <= 10)
                    $display("unexpected: tag %0d val %h last %b ment %0d done %b st %0d",
                             m_item.field_tag, m_item.field_value, m_item.field_last,
                             m_item.mention_number, m_item.payload_done, m_item.parse_status);
            end else begin
                want = expected_fields.pop_front();
                if (m_item.field_tag !== want.field_tag ||
                    m_item.field_value !== want.field_value ||
                    m_item.field_last !== want.field_last ||
                    m_item.mention_number !== want.mention_number ||
                    m_item.payload_done !== want.payload_done ||
                    m_item.parse_status !== want.parse_status) begin
                    field_errors++;
                    if (field_errors <= 10) begin
                        $display("mismatch: expected tag %0d val %h last %b ment %0d done %b st %0d",
                                 want.field_tag, want.field_value, want.field_last,
                                 want.mention_number, want.payload_done, want.parse_status);
                        $display("          got      tag %0d val %h last %b ment %0d done %b st %0d",
                                 m_item.field_tag, m_item.field_value, m_item.field_last,
                                 m_item.mention_number, m_item.payload_done,
                                 m_item.parse_status);
                    end
                end
            end
        end
    end

    task automatic push_beat(input logic [7:0] data, input logic first, input logic [15:0] plen);
        in_item_t beat;
        beat.data_byte      = data;
        beat.first_byte     = first;
        beat.payload_length = plen;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_item  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        parse_byte(beat);
    endtask

    task automatic send_message(input logic [15:0] declared, input int unsigned nbeats);
        for (int unsigned i = 0; i < nbeats; i++)
            push_beat(msg_bytes[i], i == 0, (i == 0) ? declared : 16'($urandom));
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] peer_char();
        int unsigned k;
        k = $urandom_range(0, 27);
        if (k < 10) return 8'h30 + 8'(k);
        if (k < 16) return 8'h61 + 8'(k - 10);
        if (k < 22) return 8'h41 + 8'(k - 16);
        return 8'($urandom);
    endfunction

    task automatic add_field(input int unsigned len);
        add_byte(8'(len));
        repeat (len) add_byte(8'($urandom));
    endtask

    task automatic build_message();
        logic [7:0]  flags;
        int unsigned clen;
        int unsigned n;
        msg_bytes.delete();
        flags = 8'($urandom);
        add_byte(flags);
        repeat (8) add_byte(8'($urandom));
        add_field($urandom_range(0, 4));
        add_field($urandom_range(0, 4));
        // a rare long body exercises the high length byte
        clen = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
        add_byte(8'(clen >> 8));
        add_byte(8'(clen));
        repeat (clen) add_byte(8'($urandom));
        if (flags[2]) add_field($urandom_range(0, 3));
        if (flags[3]) add_field($urandom_range(0, 3));
        if (flags[4]) begin
            n = $urandom_range(0, 7);
            add_byte(8'(n));
            repeat (n) add_byte(peer_char());
        end
        if (flags[5]) begin
            n = $urandom_range(0, 3);
            add_byte(8'(n));
            repeat (n) add_field($urandom_range(0, 3));
        end
        if (flags[6]) add_field($urandom_range(0, 3));
    endtask

    task automatic test_stray_byte();
        msg_bytes = '{8'hA5};
        push_beat(msg_bytes[0], 1'b0, 16'hFFFF);
    endtask

    task automatic test_short_payloads();
        msg_bytes = '{8'h00};
        send_message(16'd0, 1);
        msg_bytes = '{8'hFF};
        send_message(MIN_PAYLOAD - 16'd1, 1);
    endtask

    // every flag set: encrypted body, all optional fields, an invalid peer pair,
    // an odd peer char, an empty mention and an empty sender
    task automatic test_full_payload();
        msg_bytes = '{8'hFF,
                      8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                      8'h01, 8'hC3,
                      8'h00,
                      8'h00, 8'h02, 8'h68, 8'h69,
                      8'h00,
                      8'h00,
                      8'h05, 8'h61, 8'h46, 8'h67, 8'h31, 8'h33,
                      8'h02, 8'h01, 8'h78, 8'h00,
                      8'h01, 8'h63};
        send_message(16'(msg_bytes.size()), msg_bytes.size());
    endtask

    task automatic test_random_payloads(input int unsigned target);
        int unsigned done_beats;
        int unsigned pick;
        int unsigned n;
        int unsigned sz;
        done_beats = 0;
        while (done_beats < target) begin
            build_message();
            sz   = msg_bytes.size();
            pick = $urandom_range(99);
            if (pick < 50) begin
                n = sz;
                if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom));
                send_message(16'(msg_bytes.size()), msg_bytes.size());
            end else if (pick < 75) begin
                // payload ends early: overflows, truncation, missing lengths
                n = (sz > MIN_PAYLOAD) ? $urandom_range(MIN_PAYLOAD, sz - 1) : sz;
                send_message(16'(n), n);
            end else if (pick < 82) begin
                msg_bytes[$urandom_range(9, sz - 1)] = 8'($urandom);
                n = sz;
                send_message(16'(sz), sz);
            end else if (pick < 90) begin
                // dropped midway by the next first beat
                n = $urandom_range(1, sz);
                send_message(16'($urandom_range(MIN_PAYLOAD, 65535)), n);
            end else if (pick < 95) begin
                n = $urandom_range(1, 3);
                send_message(16'($urandom_range(0, MIN_PAYLOAD - 1)), n);
            end else begin
                n = 0;
                repeat ($urandom_range(1, 4)) push_beat(8'($urandom), 1'b0, 16'($urandom));
            end
            done_beats += n;
            if (pick == 42) pause_until_drained();
        end
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        m_ready      = 1'b0;
        field_errors = 0;
        src_idle_pct = 12;
        rcv_idle_pct = 83;
        clear_parser();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_stray_byte();
        test_short_payloads();
        test_full_payload();
        test_random_payloads(200);
        pause_until_drained();

        src_idle_pct = 83;
        rcv_idle_pct = 12;
        test_random_payloads(200);
        pause_until_drained();

        src_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_payloads(200);
        pause_until_drained();

        repeat (10) @(posedge aclk);
        if (field_errors == 0 && expected_fields.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/cmpp_pkg.sv
design/cmpp_core.sv
design/chat_message_payload_parser.sv
tb/tb.sv
